// ===== design/tspi_pkg.sv =====
// ----------------------------------------------------------------------------
// tspi_pkg
// Shared codes, widths and controller/datapath interface types for the
// time-stamped path interpolator.
// ----------------------------------------------------------------------------
package tspi_pkg;

  localparam int COORD_W = 16;
  localparam int XY_W    = 17;
  localparam int LB_W    = 10;
  localparam int CMD_W   = 3;
  localparam int STAT_W  = 2;

  localparam logic [LB_W-1:0] LB_RESET = 10'd90;

  typedef logic [CMD_W-1:0] cmd_code_t;

  localparam cmd_code_t CMD_START = 3'd0;
  localparam cmd_code_t CMD_ADD   = 3'd1;
  localparam cmd_code_t CMD_END   = 3'd2;
  localparam cmd_code_t CMD_CLEAR = 3'd3;
  localparam cmd_code_t CMD_POS   = 3'd4;
  localparam cmd_code_t CMD_VEL   = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_NODRAW = 2'd2;

  typedef struct packed {
    logic latch;
    logic apply;
    logic scan_init;
    logic use_back;
    logic scan;
    logic mul;
    logic div;
    logic fin;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_code_t code;
    logic      hd;
    logic      scan_done;
    logic      div_done;
    logic      back_phase;
  } dp_stat_t;

endpackage

// ===== design/tspi_ctrl.sv =====
// ----------------------------------------------------------------------------
// tspi_ctrl
// Sequencer: accepts a request, runs the segment scan, multiply and divide
// steps for one or two lookups, and hands the result to the output register.
// ----------------------------------------------------------------------------
module tspi_ctrl
  import tspi_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  output ctrl_cmd_t  cmd,
  input  dp_stat_t   stat
);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_SCAN, S_MUL, S_DIV, S_FIN, S_RESP
  } state_t;

  state_t state;
  logic   is_query;

  always_comb begin
    is_query = (stat.code == CMD_POS) || (stat.code == CMD_VEL);
    cmd      = '0;
    in_ready = (state == S_IDLE);
    unique case (state)
      S_IDLE: cmd.latch = in_valid;
      S_EXEC: begin
        cmd.apply = 1'b1;
        if (is_query && stat.hd) begin
          cmd.scan_init = 1'b1;
          cmd.use_back  = (stat.code == CMD_VEL);
        end
      end
      S_SCAN: cmd.scan = 1'b1;
      S_MUL:  cmd.mul  = 1'b1;
      S_DIV:  cmd.div  = 1'b1;
      S_FIN:  cmd.fin  = 1'b1;
      S_RESP: cmd.load_out = !out_valid || out_ready;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (in_valid) state <= S_EXEC;
        S_EXEC: state <= (is_query && stat.hd) ? S_SCAN : S_RESP;
        S_SCAN: if (stat.scan_done) state <= S_MUL;
        S_MUL:  state <= S_DIV;
        S_DIV:  if (stat.div_done) state <= S_FIN;
        S_FIN:  state <= stat.back_phase ? S_SCAN : S_RESP;
        S_RESP: if (cmd.load_out) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/tspi_dp.sv =====
// ----------------------------------------------------------------------------
// tspi_dp
// Datapath: point memories, record state, segment scan, one multiplier and a
// restoring divider per axis, and the result registers.
// ----------------------------------------------------------------------------
module tspi_dp
  import tspi_pkg::*;
#(
  parameter int MAX_POINTS = 1024,
  parameter int TIME_BITS  = 24
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ctrl_cmd_t                 cmd,
  output dp_stat_t                  stat,
  input  cmd_code_t                 in_cmd,
  input  logic signed [COORD_W-1:0] in_x,
  input  logic signed [COORD_W-1:0] in_y,
  input  logic [TIME_BITS-1:0]      in_ev,
  input  logic [TIME_BITS-1:0]      in_qt,
  input  logic                      cfg_we,
  input  logic [LB_W-1:0]           cfg_lb,
  output logic signed [XY_W-1:0]    o_x,
  output logic signed [XY_W-1:0]    o_y,
  output logic                      o_hd,
  output logic [TIME_BITS-1:0]      o_dur,
  output logic [STAT_W-1:0]         o_status
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int PW = XY_W + TIME_BITS;
  localparam int KW = $clog2(PW + 1);
  localparam int BW = TIME_BITS + LB_W;

  logic signed [COORD_W-1:0] mem_x [MAX_POINTS];
  logic signed [COORD_W-1:0] mem_y [MAX_POINTS];
  logic [TIME_BITS-1:0]      mem_t [MAX_POINTS];

  cmd_code_t                 cmd_q;
  logic signed [COORD_W-1:0] x_q, y_q;
  logic [TIME_BITS-1:0]      ev_q, qt_q;

  logic [CW-1:0]             count;
  logic                      recording;
  logic [TIME_BITS-1:0]      start_time, last_time;
  logic [LB_W-1:0]           lookback;

  logic [CW-1:0]             ra;
  logic                      rv, hp, found, back_phase;
  logic [KW-1:0]             k;
  logic signed [COORD_W-1:0] rd_x, rd_y, pv_x, pv_y;
  logic [TIME_BITS-1:0]      rd_t, pv_t, tq;
  logic signed [COORD_W-1:0] sa_x, sa_y, sb_x, sb_y;
  logic [TIME_BITS-1:0]      s_ta, s_tb, whole;
  logic                      negx, negy;
  logic [PW-1:0]             dvx, dvy;
  logic [TIME_BITS-1:0]      remx, remy;
  logic signed [XY_W-1:0]    px, py, res_x, res_y;
  logic [STAT_W-1:0]         st;

  logic                      hd, full, we, issue, scan_rst;
  logic [AW-1:0]             wa;
  logic [TIME_BITS-1:0]      wt, rel, bt, part, whole_c;
  logic [BW-1:0]             qe, le;
  logic signed [XY_W-1:0]    dx, dy, rx, ry;
  logic [XY_W-1:0]           magx, magy;
  logic [TIME_BITS:0]        shx, shy, wext;
  logic                      gex, gey;

  function automatic logic signed [XY_W-1:0] axis_res(
    input logic                      fnd,
    input logic                      wz,
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b,
    input logic                      neg,
    input logic [XY_W-1:0]           q
  );
    logic signed [XY_W-1:0] ae;
    ae = XY_W'(a);
    if (!fnd) return '0;
    if (wz) return XY_W'(b);
    return neg ? ae - $signed(q) : ae + $signed(q);
  endfunction

  always_comb begin
    hd      = !recording && (count >= CW'(2));
    full    = (count == CW'(MAX_POINTS));
    rel     = ev_q - start_time;
    we      = cmd.apply && ((cmd_q == CMD_START) || ((cmd_q == CMD_ADD) && !full));
    wa      = (cmd_q == CMD_START) ? '0 : count[AW-1:0];
    wt      = (cmd_q == CMD_START) ? '0 : rel;
    qe      = BW'(qt_q);
    le      = BW'(lookback);
    bt      = (qe > le) ? TIME_BITS'(qe - le) : '0;
    issue   = ra < count;
    scan_rst = cmd.scan_init || (cmd.fin && back_phase);
    part    = tq - s_ta;
    whole_c = s_tb - s_ta;
    dx      = XY_W'(sb_x) - XY_W'(sa_x);
    dy      = XY_W'(sb_y) - XY_W'(sa_y);
    magx    = dx[XY_W-1] ? XY_W'(-dx) : XY_W'(dx);
    magy    = dy[XY_W-1] ? XY_W'(-dy) : XY_W'(dy);
    wext    = {1'b0, whole};
    shx     = {remx, dvx[PW-1]};
    shy     = {remy, dvy[PW-1]};
    gex     = shx >= wext;
    gey     = shy >= wext;
    rx      = axis_res(found, whole == '0, sa_x, sb_x, negx, dvx[XY_W-1:0]);
    ry      = axis_res(found, whole == '0, sa_y, sb_y, negy, dvy[XY_W-1:0]);
    stat.code       = cmd_q;
    stat.hd         = hd;
    stat.scan_done  = (ra == count) && !rv;
    stat.div_done   = (k == KW'(PW));
    stat.back_phase = back_phase;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_x[wa] <= x_q;
      mem_y[wa] <= y_q;
      mem_t[wa] <= wt;
    end
    rd_x <= mem_x[ra[AW-1:0]];
    rd_y <= mem_y[ra[AW-1:0]];
    rd_t <= mem_t[ra[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      recording  <= 1'b0;
      start_time <= '0;
      lookback   <= LB_RESET;
      ra         <= '0;
      rv         <= 1'b0;
      hp         <= 1'b0;
      found      <= 1'b0;
      back_phase <= 1'b0;
      k          <= '0;
    end else begin
      if (cfg_we) lookback <= cfg_lb;
      if (cmd.apply) begin
        case (cmd_q)
          CMD_START: begin
            start_time <= ev_q;
            count      <= CW'(1);
            recording  <= 1'b1;
          end
          CMD_ADD:   if (!full) count <= count + CW'(1);
          CMD_END:   recording <= 1'b0;
          CMD_CLEAR: count <= '0;
          default:   ;
        endcase
      end
      if (scan_rst) begin
        ra    <= '0;
        rv    <= 1'b0;
        hp    <= 1'b0;
        found <= 1'b0;
      end else if (cmd.scan) begin
        if (issue) ra <= ra + CW'(1);
        rv <= issue;
        if (rv) begin
          hp <= 1'b1;
          if (hp && (tq >= pv_t) && (tq <= rd_t)) found <= 1'b1;
        end
      end
      if (cmd.scan_init) back_phase <= cmd.use_back;
      else if (cmd.fin) back_phase <= 1'b0;
      if (cmd.mul) k <= '0;
      else if (cmd.div && !stat.div_done) k <= k + KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_q <= in_cmd;
      x_q   <= in_x;
      y_q   <= in_y;
      ev_q  <= in_ev;
      qt_q  <= in_qt;
    end
    if (cmd.apply) begin
      res_x <= '0;
      res_y <= '0;
      if (cmd_q == CMD_START) last_time <= '0;
      if ((cmd_q == CMD_ADD) && !full) last_time <= rel;
      if ((cmd_q == CMD_ADD) && full) begin
        st <= ST_FULL;
      end else if (((cmd_q == CMD_POS) || (cmd_q == CMD_VEL)) && !hd) begin
        st <= ST_NODRAW;
      end else begin
        st <= ST_OK;
      end
    end
    if (cmd.scan_init) tq <= cmd.use_back ? bt : qt_q;
    if (cmd.scan && rv) begin
      pv_x <= rd_x;
      pv_y <= rd_y;
      pv_t <= rd_t;
      if (hp && (tq >= pv_t) && (tq <= rd_t)) begin
        sa_x <= pv_x;
        sa_y <= pv_y;
        sb_x <= rd_x;
        sb_y <= rd_y;
        s_ta <= pv_t;
        s_tb <= rd_t;
      end
    end
    if (cmd.mul) begin
      whole <= whole_c;
      negx  <= dx[XY_W-1];
      negy  <= dy[XY_W-1];
      dvx   <= PW'(magx) * PW'(part);
      dvy   <= PW'(magy) * PW'(part);
      remx  <= '0;
      remy  <= '0;
    end else if (cmd.div && !stat.div_done) begin
      remx <= gex ? TIME_BITS'(shx - wext) : shx[TIME_BITS-1:0];
      remy <= gey ? TIME_BITS'(shy - wext) : shy[TIME_BITS-1:0];
      dvx  <= {dvx[PW-2:0], gex};
      dvy  <= {dvy[PW-2:0], gey};
    end
    if (cmd.fin) begin
      if (back_phase) begin
        px <= rx;
        py <= ry;
        tq <= qt_q;
      end else begin
        res_x <= (cmd_q == CMD_VEL) ? rx - px : rx;
        res_y <= (cmd_q == CMD_VEL) ? ry - py : ry;
      end
    end
    if (cmd.load_out) begin
      o_x      <= res_x;
      o_y      <= res_y;
      o_hd     <= hd;
      o_dur    <= hd ? last_time : '0;
      o_status <= st;
    end
  end

endmodule

// ===== design/time_stamped_path_interpolator.sv =====
// Start, add, end, clear: the request is applied in S_EXEC and its result loaded in S_RESP.
// Position query: set by the one-read-a-cycle segment scan over the N stored points,
//   then a multiply and the bit-serial divider before the result is loaded.
// Velocity query: two lookups, each with its own scan, multiply and divide.
// One request at a time; a waiting result does not block the next request.
// Synchronous reset empties the path, clears recording, lookback back to 90.
// ----------------------------------------------------------------------------
// time_stamped_path_interpolator
// Records time-stamped 2D points and answers position and velocity queries
// by linear interpolation over the stored path.
// ----------------------------------------------------------------------------
module time_stamped_path_interpolator
  import tspi_pkg::*;
#(
  parameter int MAX_POINTS = 1024,
  parameter int TIME_BITS  = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // pos_x, pos_y, event_time_ms, query_time_ms
  input  logic [((2*COORD_W+2*TIME_BITS+7)/8)*8-1:0] s_tdata,
  // command
  input  logic [CMD_W-1:0]             s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // out_x, out_y, duration_ms
  output logic [((2*XY_W+TIME_BITS+7)/8)*8-1:0] m_tdata,
  // have_drawing, status
  output logic [STAT_W:0]              m_tuser,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [LB_W-1:0]              cfg_data
);

  ctrl_cmd_t              cmd;
  dp_stat_t               stat;
  logic signed [XY_W-1:0] o_x, o_y;
  logic                   o_hd;
  logic [TIME_BITS-1:0]   o_dur;
  logic [STAT_W-1:0]      o_status;

  assign cfg_ready = 1'b1;

  tspi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .cmd       (cmd),
    .stat      (stat)
  );

  tspi_dp #(
    .MAX_POINTS (MAX_POINTS),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_cmd   (s_tuser),
    .in_x     (s_tdata[COORD_W-1:0]),
    .in_y     (s_tdata[2*COORD_W-1:COORD_W]),
    .in_ev    (s_tdata[2*COORD_W+TIME_BITS-1:2*COORD_W]),
    .in_qt    (s_tdata[2*COORD_W+2*TIME_BITS-1:2*COORD_W+TIME_BITS]),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_lb   (cfg_data),
    .o_x      (o_x),
    .o_y      (o_y),
    .o_hd     (o_hd),
    .o_dur    (o_dur),
    .o_status (o_status)
  );

  always_comb begin
    m_tdata = '0;
    m_tdata[XY_W-1:0] = o_x;
    m_tdata[2*XY_W-1:XY_W] = o_y;
    m_tdata[2*XY_W+TIME_BITS-1:2*XY_W] = o_dur;
    m_tuser = {o_status, o_hd};
  end

endmodule

// ===== design/tspi_check.sv =====
// ----------------------------------------------------------------------------
// tspi_check
// Port-level checks for the time-stamped path interpolator.
// ----------------------------------------------------------------------------
module tspi_check
  import tspi_pkg::*;
#(
  parameter int TIME_BITS = 24
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [((2*XY_W+TIME_BITS+7)/8)*8-1:0] m_tdata,
  input logic [STAT_W:0]              m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[STAT_W:1] == ST_OK) || (m_tuser[STAT_W:1] == ST_FULL)
      || (m_tuser[STAT_W:1] == ST_NODRAW))
    else $error("undefined status code");

  a_dur: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[2*XY_W+TIME_BITS-1:2*XY_W] == '0)
    else $error("duration without drawing");

  a_nodraw: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[STAT_W:1] == ST_NODRAW)
      |-> !m_tuser[0] && (m_tdata[2*XY_W-1:0] == '0))
    else $error("no-drawing result carries data");

endmodule

bind time_stamped_path_interpolator tspi_check #(.TIME_BITS(TIME_BITS)) u_check (.*);

// ===== sim/tspi_checker.sv =====
// ----------------------------------------------------------------------------
// tspi_checker
// Watches the request, result and lookback channels of the path interpolator,
// predicts every result from its own copy of the path store and compares.
// ----------------------------------------------------------------------------
module tspi_checker
  import tspi_pkg::*;
#(
  parameter int MAX_POINTS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [79:0] s_tdata,
  input  logic [2:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,
  input  logic [2:0]  m_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [9:0]  cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    logic signed [16:0] x;
    logic signed [16:0] y;
    logic               hd;
    logic [23:0]        dur;
    logic [1:0]         st;
  } answer_t;

  logic signed [15:0] path_x [MAX_POINTS];
  logic signed [15:0] path_y [MAX_POINTS];
  logic [23:0]        path_t [MAX_POINTS];
  int unsigned        npts;
  logic               recording;
  logic [23:0]        t0;
  logic [9:0]         lookback;
  answer_t            answers [$];

  function automatic int lerp(int a, int b, longint part, longint whole);
    longint d;
    longint m;
    d = b - a;
    if (whole == 0) return b;
    m = (d < 0 ? -d : d) * part / whole;
    return d < 0 ? a - int'(m) : a + int'(m);
  endfunction

  function automatic void locate(logic [23:0] t, output int px, output int py);
    px = 0;
    py = 0;
    for (int i = 0; i + 1 < npts; i++) begin
      if (t >= path_t[i] && t <= path_t[i+1]) begin
        px = lerp(path_x[i], path_x[i+1], t - path_t[i], path_t[i+1] - path_t[i]);
        py = lerp(path_y[i], path_y[i+1], t - path_t[i], path_t[i+1] - path_t[i]);
      end
    end
  endfunction

  function automatic logic drawing();
    return !recording && npts >= 2;
  endfunction

  task automatic predict(logic [2:0] code, logic [79:0] d);
    answer_t a;
    int cx, cy, bx, by;
    logic [23:0] qt, back;
    a = '{default: '0};
    qt = d[79:56];
    case (code)
      CMD_START: begin
        t0 = d[55:32];
        path_x[0] = d[15:0];
        path_y[0] = d[31:16];
        path_t[0] = '0;
        npts = 1;
        recording = 1'b1;
      end
      CMD_ADD: begin
        if (npts >= MAX_POINTS) a.st = ST_FULL;
        else begin
          path_x[npts] = d[15:0];
          path_y[npts] = d[31:16];
          path_t[npts] = d[55:32] - t0;
          npts++;
        end
      end
      CMD_END: recording = 1'b0;
      CMD_CLEAR: npts = 0;
      CMD_POS: begin
        if (!drawing()) a.st = ST_NODRAW;
        else begin
          locate(qt, cx, cy);
          a.x = 17'(cx);
          a.y = 17'(cy);
        end
      end
      CMD_VEL: begin
        if (!drawing()) a.st = ST_NODRAW;
        else begin
          back = qt > lookback ? qt - lookback : '0;
          locate(back, bx, by);
          locate(qt, cx, cy);
          a.x = 17'(cx - bx);
          a.y = 17'(cy - by);
        end
      end
      default: ;
    endcase
    a.hd = drawing();
    if (a.hd) a.dur = path_t[npts-1];
    answers.insert(answers.size(), a);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  always @(posedge clk) begin
    answer_t e;
    if (rst) begin
      npts = 0;
      recording = 1'b0;
      t0 = '0;
      lookback = LB_RESET;
      answers.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) lookback = cfg_data;
      if (m_tvalid && m_tready) begin
        if (answers.size() == 0) report_mismatch("unexpected result", m_tdata, 0);
        else begin
          e = answers.pop_front();
          if (m_tdata[16:0] !== e.x) report_mismatch("out_x", m_tdata[16:0], e.x);
          if (m_tdata[33:17] !== e.y) report_mismatch("out_y", m_tdata[33:17], e.y);
          if (m_tdata[57:34] !== e.dur) report_mismatch("duration", m_tdata[57:34], e.dur);
          if (m_tuser[0] !== e.hd) report_mismatch("have_drawing", m_tuser[0], e.hd);
          if (m_tuser[2:1] !== e.st) report_mismatch("status", m_tuser[2:1], e.st);
        end
      end
      if (s_tvalid && s_tready) predict(s_tuser, s_tdata);
    end
    pending = answers.size();
  end

endmodule

// ===== sim/time_stamped_path_interpolator_test.sv =====
// ----------------------------------------------------------------------------
// time_stamped_path_interpolator_test
// Drives recording sessions, queries and lookback settings into the path
// interpolator under random bursts and stalls; the checker scores results.
// ----------------------------------------------------------------------------
module time_stamped_path_interpolator_test;
  import tspi_pkg::*;

  localparam cmd_code_t CMD_SPARE_LO = 3'd6;
  localparam cmd_code_t CMD_SPARE_HI = 3'd7;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [79:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [9:0]  cfg_data;
  int          fail_count;
  int          pending;
  longint      cycles;
  logic [23:0] clock_ms;
  logic [23:0] span_ms;

  time_stamped_path_interpolator u_top (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .cfg_valid, .cfg_ready, .cfg_data
  );

  tspi_checker u_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .cfg_valid, .cfg_ready, .cfg_data,
    .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd4000000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver stall pattern: runs of ready and stall of varying length
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      case ($urandom_range(0, 9))
        0: m_tready <= 1'b0;
        1, 2: m_tready <= ~m_tready;
        default: m_tready <= 1'b1;
      endcase
    end
  end

  task automatic send(cmd_code_t code, logic [15:0] x, logic [15:0] y,
                      logic [23:0] ev, logic [23:0] qt);
    s_tvalid <= 1'b1;
    s_tuser <= code;
    s_tdata <= {qt, ev, y, x};
    do @(posedge clk); while (!s_tready);
    if ($urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic write_lookback(logic [9:0] v);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4000) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic rand_point(cmd_code_t code, int step);
    clock_ms = 24'(clock_ms + step);
    send(code, 16'($urandom), 16'($urandom), clock_ms, 24'($urandom));
  endtask

  task automatic query();
    logic [23:0] qt;
    case ($urandom_range(0, 5))
      0: qt = 24'($urandom);
      1: qt = 24'(span_ms + $urandom_range(0, 3));
      default: qt = 24'($urandom_range(0, span_ms));
    endcase
    send($urandom_range(0, 1) ? CMD_POS : CMD_VEL, 16'($urandom), 16'($urandom),
         24'($urandom), qt);
  endtask

  task automatic session();
    int n;
    int step;
    n = $urandom_range(1, 12);
    span_ms = 0;
    clock_ms = 24'($urandom);
    send(CMD_START, 16'($urandom), 16'($urandom), clock_ms, 24'($urandom));
    for (int i = 0; i < n; i++) begin
      step = $urandom_range(0, 3) == 0 ? 0 : int'($urandom_range(1, 400));
      if ($urandom_range(0, 15) == 0) step = -int'($urandom_range(1, 50));
      rand_point(CMD_ADD, step);
      span_ms = 24'(span_ms + step);
    end
    if ($urandom_range(0, 7) == 0) query();
    send(CMD_END, 16'($urandom), 16'($urandom), 24'($urandom), 24'($urandom));
    repeat ($urandom_range(3, 8)) query();
    if ($urandom_range(0, 5) == 0) begin
      send(cmd_code_t'($urandom_range(0, 7)), 16'($urandom), 16'($urandom),
           24'($urandom), 24'($urandom));
      query();
    end
  endtask

  initial begin
    rst = 1'b1;
    cycles = 0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(CMD_POS, 0, 0, 0, 0);
    send(CMD_VEL, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send(CMD_START, 16'h8000, 16'h7FFF, 24'hFFFFF0, 0);
    send(CMD_ADD, 16'h7FFF, 16'h8000, 24'h000010, 0);
    send(CMD_ADD, 16'h0000, 16'h0000, 24'h000010, 0);
    send(CMD_ADD, 16'hFFFF, 16'h1234, 24'h000100, 0);
    send(CMD_POS, 0, 0, 0, 24'd5);
    send(CMD_END, 0, 0, 0, 0);
    send(CMD_POS, 0, 0, 0, 24'd0);
    send(CMD_POS, 0, 0, 0, 24'd16);
    send(CMD_POS, 0, 0, 0, 24'd31);
    send(CMD_POS, 0, 0, 0, 24'hFFFFFF);
    send(CMD_VEL, 0, 0, 0, 24'd200);
    send(CMD_VEL, 0, 0, 0, 24'd40);
    send(CMD_ADD, 16'h0100, 16'h0100, 24'h000000, 0);
    send(CMD_POS, 0, 0, 0, 24'd100);
    send(CMD_SPARE_LO, 0, 0, 0, 0);
    send(CMD_SPARE_HI, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send(CMD_CLEAR, 0, 0, 0, 0);
    send(CMD_VEL, 0, 0, 0, 24'd10);

    // long path with short steps, then queries across it
    send(CMD_START, 1, 2, 0, 0);
    clock_ms = 0;
    for (int i = 1; i < 41; i++) rand_point(CMD_ADD, int'($urandom_range(0, 3)));
    send(CMD_END, 0, 0, 0, 0);
    send(CMD_POS, 0, 0, 0, 24'd45);
    send(CMD_VEL, 0, 0, 0, 24'd1500);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_lookback(10'd0);
        1: write_lookback(10'd1023);
        2: write_lookback(10'd1000);
        3: write_lookback(10'd1);
        default: write_lookback(10'($urandom_range(0, 1023)));
      endcase
      for (int s = 0; s < 3; s++) session();
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4000) @(posedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
